// File: rtl/core/kmpm_pkg.sv
// ----------------------------------------------------------------------------
// kmpm_pkg
// Shared types and constants of the KMP pattern matcher: field widths,
// register codes and the structs passed between front, table and search.
// ----------------------------------------------------------------------------
package kmpm_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 5;    // match length, pattern length, table entry
   localparam int START_W     = 16;   // match_start field
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int PAT_BYTES   = 16;   // bytes held by the two pattern registers
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LOW    = 2'd0,
      REG_PATTERN_HIGH   = 2'd1,
      REG_PATTERN_LENGTH = 2'd2
   } csr_reg_type;

   // queue head as seen by the search engine
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] text_byte;
      logic              last_byte;
   } queue_head_type;

   // pattern store / failure table status toward the search engine
   typedef struct packed {
      logic              building;   // table build in progress
      logic              restart;    // accepted register write, clears search
      logic [BYTE_W-1:0] pat_byte;   // pattern byte at the search's match length
      logic [LEN_W-1:0]  fail;       // failure link at the search's match length
      logic [LEN_W-1:0]  len;        // pattern length in use, clamped
   } pat_status_type;

endpackage

// File: rtl/core/kmpm_if.sv
// ----------------------------------------------------------------------------
// kmpm_req_if / kmpm_rsp_if
// Valid/ready channels of the KMP pattern matcher: text items in, verdicts out.
// ----------------------------------------------------------------------------
interface kmpm_req_if;
   import kmpm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface kmpm_rsp_if;
   import kmpm_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [START_W-1:0] match_start;
   logic               end_of_text;
   logic               position_overflow;

   modport source (output valid, output found, output match_start,
                   output end_of_text, output position_overflow, input ready);
   modport sink   (input valid, input found, input match_start,
                   input end_of_text, input position_overflow, output ready);
endinterface

// File: rtl/core/kmpm_front.sv
// ----------------------------------------------------------------------------
// kmpm_front
// Input side: accepts text items into a two-entry queue that decouples the
// request channel from the search engine.
// ----------------------------------------------------------------------------
module kmpm_front (
   input  logic                     clock,
   input  logic                     reset,
   kmpm_req_if.sink                 req_if,
   input  logic                     building,
   input  logic                     pop,
   output kmpm_pkg::queue_head_type head
);
   import kmpm_pkg::*;

   logic [BYTE_W-1:0] byte_ff [QUEUE_DEPTH];
   logic              last_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              do_pop;

   // no intake while the failure table is rebuilt
   assign req_if.ready = (count_ff != QCNT_W'(QUEUE_DEPTH)) && !building;
   assign push         = req_if.valid && req_if.ready;
   assign do_pop       = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         byte_ff[wr_ptr_ff] <= req_if.text_byte;
         last_ff[wr_ptr_ff] <= req_if.last_byte;
      end
   end

   assign head.valid     = (count_ff != '0);
   assign head.text_byte = byte_ff[rd_ptr_ff];
   assign head.last_byte = last_ff[rd_ptr_ff];

endmodule

// File: rtl/core/kmpm_pattern.sv
// ----------------------------------------------------------------------------
// kmpm_pattern
// Pattern registers and failure table. A sequencer rebuilds the table after
// reset and after every register write, one comparison per cycle.
// ----------------------------------------------------------------------------
module kmpm_pattern #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kmpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kmpm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [kmpm_pkg::LEN_W-1:0]        search_len,
   output kmpm_pkg::pat_status_type          status
);
   import kmpm_pkg::*;

   localparam int TIW = $clog2(MAX_PATTERN);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } build_state_type;

   build_state_type    state_ff, state_in;
   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_hi_ff;
   logic [LEN_W-1:0]   len_raw_ff;
   logic [LEN_W-1:0]   i_ff, i_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   logic [LEN_W-1:0]   fail_ff [MAX_PATTERN];

   logic               csr_hit;
   logic [LEN_W-1:0]   len_used;
   logic [LEN_W-1:0]   i_next;
   logic [LEN_W-1:0]   rd_addr;
   logic [LEN_W-1:0]   fail_rd;
   logic [BYTE_W-1:0]  pat_i, pat_k;
   logic               tbl_we;
   logic [LEN_W-1:0]   k_ext;

   function automatic logic [BYTE_W-1:0] pat_at(input logic [CSR_DATA_W-1:0] lo,
                                                input logic [CSR_DATA_W-1:0] hi,
                                                input logic [3:0] k);
      logic [CSR_DATA_W-1:0] w;
      w = k[3] ? hi : lo;
      return w[{k[2:0], 3'b000} +: BYTE_W];
   endfunction

   always_comb begin
      case (csr_index)
         REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH: csr_hit = csr_we;
         default:                                              csr_hit = 1'b0;
      endcase
   end

   always_comb begin
      if (len_raw_ff == '0) begin
         len_used = LEN_W'(1);
      end else if (len_raw_ff > LEN_W'(MAX_PATTERN)) begin
         len_used = LEN_W'(MAX_PATTERN);
      end else begin
         len_used = len_raw_ff;
      end
   end

   // single table read port: the builder owns it while running
   assign rd_addr = (state_ff == B_RUN) ? k_ff : search_len;
   assign fail_rd = (rd_addr <= LEN_W'(1)) ? '0 : fail_ff[rd_addr[TIW-1:0]];

   assign pat_i  = pat_at(pat_lo_ff, pat_hi_ff, i_ff[3:0]);
   assign pat_k  = pat_at(pat_lo_ff, pat_hi_ff, k_ff[3:0]);
   assign i_next = LEN_W'(i_ff + 1'b1);
   assign k_ext  = (pat_i == pat_k) ? LEN_W'(k_ff + 1'b1) : k_ff;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      tbl_we   = 1'b0;
      case (state_ff)
         B_RUN: begin
            if (i_next >= len_used) begin
               state_in = B_IDLE;
            end else if ((k_ff != '0) && (pat_i != pat_k)) begin
               k_in = fail_rd;            // follow one link
            end else begin
               k_in   = k_ext;
               i_in   = i_next;
               tbl_we = 1'b1;
            end
         end
         B_IDLE: begin
         end
         default: state_in = B_IDLE;
      endcase
      if (csr_hit) begin
         state_in = B_RUN;
         i_in     = LEN_W'(1);
         k_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_RUN;
         i_ff       <= LEN_W'(1);
         k_ff       <= '0;
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         len_raw_ff <= LEN_W'(1);
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         if (csr_we) begin
            case (csr_index)
               REG_PATTERN_LOW:    pat_lo_ff  <= csr_wdata;
               REG_PATTERN_HIGH:   pat_hi_ff  <= csr_wdata;
               REG_PATTERN_LENGTH: len_raw_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we && !csr_hit) begin
         fail_ff[i_next[TIW-1:0]] <= k_ext;
      end
   end

   assign status.building = (state_ff == B_RUN);
   assign status.restart  = csr_hit;
   assign status.pat_byte = pat_at(pat_lo_ff, pat_hi_ff, search_len[3:0]);
   assign status.fail     = fail_rd;
   assign status.len      = len_used;

endmodule

// File: rtl/core/kmpm_search.sv
// ----------------------------------------------------------------------------
// kmpm_search
// Search engine: takes the queue head, follows one failure link per cycle
// on a mismatch, then updates the match state and registers the verdict.
// ----------------------------------------------------------------------------
module kmpm_search #(
   parameter int INDEX_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmpm_pkg::pat_status_type      status,
   input  kmpm_pkg::queue_head_type      head,
   output logic                          pop,
   output logic [kmpm_pkg::LEN_W-1:0]    match_len,
   kmpm_rsp_if.source                    rsp_if
);
   import kmpm_pkg::*;

   logic [LEN_W-1:0]      m_ff, m_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [INDEX_BITS-1:0] start_ff, start_in;
   logic                  found_ff, found_in;
   logic                  ovf_ff, ovf_in;

   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [START_W-1:0]    rsp_start_ff;
   logic                  rsp_eot_ff;
   logic                  rsp_ovf_ff;

   logic                  active, searching, saturated, mismatch, link, out_free;
   logic [LEN_W-1:0]      m_ext;
   logic [INDEX_BITS+START_W-1:0] start_wide;

   assign saturated = &idx_ff;
   assign active    = head.valid && !status.building;
   assign searching = !found_ff && !ovf_ff && !saturated;
   assign mismatch  = (status.pat_byte != head.text_byte);
   assign link      = searching && (m_ff != '0) && mismatch;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop       = active && !link && out_free;
   assign m_ext     = mismatch ? m_ff : LEN_W'(m_ff + 1'b1);
   assign match_len = m_ff;

   always_comb begin
      m_in     = m_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      if (!found_ff && !ovf_ff) begin
         if (saturated) begin
            ovf_in = 1'b1;
         end else begin
            idx_in = INDEX_BITS'(idx_ff + 1'b1);
            if (m_ext >= status.len) begin
               found_in = 1'b1;
               start_in = INDEX_BITS'(idx_ff + 1'b1 - INDEX_BITS'(status.len));
               m_in     = '0;
            end else begin
               m_in = m_ext;
            end
         end
      end
   end

   assign start_wide = {START_W'(0), start_in};

   always_ff @(posedge clock) begin
      if (reset || status.restart) begin
         m_ff     <= '0;
         idx_ff   <= '0;
         start_ff <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (active && link) begin
         m_ff <= status.fail;
      end else if (pop) begin
         if (head.last_byte) begin
            m_ff     <= '0;
            idx_ff   <= '0;
            start_ff <= '0;
            found_ff <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            m_ff     <= m_in;
            idx_ff   <= idx_in;
            start_ff <= start_in;
            found_ff <= found_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_found_ff <= found_in;
         rsp_start_ff <= found_in ? start_wide[START_W-1:0] : '0;
         rsp_eot_ff   <= head.last_byte;
         rsp_ovf_ff   <= ovf_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.found             = rsp_found_ff;
   assign rsp_if.match_start       = rsp_start_ff;
   assign rsp_if.end_of_text       = rsp_eot_ff;
   assign rsp_if.position_overflow = rsp_ovf_ff;

   // the partial match is always shorter than the pattern
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      m_ff < status.len)
      else $error("match length reached pattern length");

   // a found text parks the match length at zero
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (m_ff == '0))
      else $error("match length nonzero after match");

   // overflow and match exclude each other
   a_found_ovf: assert property (@(posedge clock) disable iff (reset)
      !(found_ff && ovf_ff))
      else $error("found and overflow both set");

   // end of text clears the search
   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last_byte) |=> (idx_ff == '0 && !found_ff && !ovf_ff))
      else $error("search state not cleared after end of text");

endmodule

// File: rtl/core/kmp_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_pattern_matcher_core
// Streaming Knuth-Morris-Pratt search for the first occurrence of a pattern
// of up to MAX_PATTERN bytes; one verdict item per text item.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries text items (text_byte, last_byte); rsp_if returns one
//    item per text item: found, match_start, end_of_text, position_overflow.
//  - csr_we/csr_index/csr_wdata write the pattern registers: 0 low bytes,
//    1 high bytes, 2 length. Write only while no text item is in flight.
//  - After reset and after each register write the failure table is rebuilt,
//    one compare per cycle; req ready is low meanwhile. Search state is
//    cleared by reset and by register writes.
//  - A text item waits in the queue while any failure links for it are
//    followed; its result item is registered when it is popped.
//  - Each failure link followed holds the current item at the queue head;
//    links are taken one a cycle through the single failure-table read port.
//  - A two-entry queue sits between request channel and search engine and the
//    result is held in an output register, so a stalled receiver holds the
//    pending result and the queue soaks up two more items before req ready
//    drops.
//  - last_byte: that item's result is the final verdict; the search restarts.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher_core #(
   parameter int MAX_PATTERN = 16,
   parameter int INDEX_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   kmpm_req_if.sink                          req_if,
   kmpm_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [kmpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kmpm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kmpm_pkg::*;

   queue_head_type   head;
   pat_status_type   status;
   logic             pop;
   logic [LEN_W-1:0] match_len;

   // front: item intake and queue
   kmpm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .building (status.building),
      .pop      (pop),
      .head     (head)
   );

   // pattern registers and failure-table builder
   kmpm_pattern #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_pattern (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .search_len (match_len),
      .status     (status)
   );

   // back: KMP step engine and result register
   kmpm_search #(
      .INDEX_BITS (INDEX_BITS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head      (head),
      .pop       (pop),
      .match_len (match_len),
      .rsp_if    (rsp_if)
   );

endmodule
